[sv/dccs_pkg.sv]
// package for the duty-cycled charge sequencer
// word types, configuration block, event and register codes, back-end states
// no dependencies
package dccs_pkg;

    localparam int TIME_BITS  = 32;
    localparam int LEVEL_W    = 7;
    localparam int RETRY_W    = 8;
    localparam int MINUTES_W  = 8;
    localparam int GOAL_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int EVENT_W    = 3;

    localparam logic [GOAL_W-1:0] MS_PER_MINUTE = GOAL_W'(60 * 1000);

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_HOST_OFF = 3'd1;
    localparam logic [EVENT_W-1:0] EV_HOST_ON  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CHARGE   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_COOLDOWN = 3'd4;
    localparam logic [EVENT_W-1:0] EV_DONE     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_OFF_RETRY_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARGE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MINUTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MINUTES = 3'd4;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic [RETRY_W-1:0]   retry_count;
        logic [LEVEL_W-1:0]   battery_level;
    } t_in_word;

    typedef struct packed {
        logic               mux_select;
        logic               host_on;
        logic               charge_phase;
        logic [LEVEL_W-1:0] cycle_count;
        logic [LEVEL_W-1:0] cycles_planned;
        logic [EVENT_W-1:0] event_code;
    } t_out_word;

    typedef struct packed {
        logic [RETRY_W-1:0]   off_retry_limit;
        logic [LEVEL_W-1:0]   max_charge_level;
        logic [LEVEL_W-1:0]   charge_gain;
        logic [MINUTES_W-1:0] charge_minutes;
        logic [MINUTES_W-1:0] cooldown_minutes;
    } t_cfg;

    // classified pass as held in the queue
    typedef struct packed {
        logic [TIME_BITS-1:0] now_ms;
        logic                 retry_hit;
        logic                 plan_zero;
        logic [LEVEL_W-1:0]   level_gap;
        logic [GOAL_W-1:0]    goal_charge;
        logic [GOAL_W-1:0]    goal_cooldown;
    } t_pass;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } t_back_state;

endpackage

[sv/dccs_front.sv]
// front end: classifies each input word against the configuration
// depends on dccs_pkg
module dccs_front (
    input  dccs_pkg::t_in_word i_word,
    input  dccs_pkg::t_cfg     i_cfg,
    output dccs_pkg::t_pass    o_pass
);
    import dccs_pkg::*;

    always_comb begin
        o_pass.now_ms        = i_word.now_ms;
        o_pass.retry_hit     = (i_word.retry_count >= i_cfg.off_retry_limit);
        o_pass.plan_zero     = (i_word.battery_level > i_cfg.max_charge_level)
                               || (i_cfg.charge_gain == '0);
        o_pass.level_gap     = i_cfg.max_charge_level - i_word.battery_level;
        o_pass.goal_charge   = GOAL_W'(i_cfg.charge_minutes) * MS_PER_MINUTE;
        o_pass.goal_cooldown = GOAL_W'(i_cfg.cooldown_minutes) * MS_PER_MINUTE;
    end

endmodule

[sv/dccs_queue.sv]
// two-entry queue of classified passes between front and back end
// depends on dccs_pkg
module dccs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dccs_pkg::t_pass i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dccs_pkg::t_pass o_data
);
    import dccs_pkg::*;

    t_pass      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/dccs_back.sv]
// back end: sequencer state, cycle plan divider and output register
// depends on dccs_pkg
module dccs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [dccs_pkg::LEVEL_W-1:0] i_charge_gain,
    input  logic                i_q_valid,
    input  dccs_pkg::t_pass     i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dccs_pkg::t_out_word o_out_data
);
    import dccs_pkg::*;

    t_back_state r_state, n_state;

    logic                 r_host_on, n_host_on;
    logic                 r_phase, n_phase;
    logic [LEVEL_W-1:0]   r_index, n_index;
    logic [LEVEL_W-1:0]   r_target, n_target;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic                 r_mux, n_mux;

    logic [LEVEL_W-1:0] r_rem, n_rem;
    logic [LEVEL_W-1:0] r_quo, n_quo;
    logic [2:0]         r_cnt, n_cnt;

    logic      r_out_valid;
    t_out_word r_out;

    logic                 load;
    logic [EVENT_W-1:0]   ev;
    logic [TIME_BITS-1:0] elapsed;
    logic [GOAL_W-1:0]    goal;
    logic [LEVEL_W:0]     trial;
    logic [LEVEL_W-1:0]   index_inc;
    logic                 out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_host_on = r_host_on;
        n_phase   = r_phase;
        n_index   = r_index;
        n_target  = r_target;
        n_start   = r_start;
        n_mux     = r_mux;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;
        load      = 1'b0;
        ev        = EV_NONE;
        goal      = r_phase ? i_q_data.goal_charge : i_q_data.goal_cooldown;
        elapsed   = i_q_data.now_ms - r_start;
        trial     = {r_rem, r_quo[LEVEL_W-1]};
        index_inc = r_index + 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    if (r_host_on) begin
                        if (i_q_data.retry_hit) begin
                            n_index   = '0;
                            n_host_on = 1'b0;
                            n_mux     = 1'b0;
                            n_phase   = 1'b1;
                            n_start   = i_q_data.now_ms;
                            ev        = EV_HOST_OFF;
                            if (i_q_data.plan_zero) begin
                                n_target = '0;
                                load     = 1'b1;
                            end else begin
                                n_rem   = '0;
                                n_quo   = i_q_data.level_gap;
                                n_cnt   = '0;
                                n_state = BK_DIV;
                            end
                        end else begin
                            load = 1'b1;
                        end
                    end else if (!i_q_data.retry_hit) begin
                        n_host_on = 1'b1;
                        n_phase   = 1'b1;
                        n_index   = '0;
                        n_mux     = 1'b0;
                        ev        = EV_HOST_ON;
                        load      = 1'b1;
                    end else if (r_index < r_target) begin
                        load = 1'b1;
                        if (elapsed > TIME_BITS'(goal)) begin
                            n_start = i_q_data.now_ms;
                            n_phase = ~r_phase;
                            n_mux   = r_phase;
                            if (r_phase) begin
                                n_index = index_inc;
                                ev = (index_inc == r_target) ? EV_DONE : EV_COOLDOWN;
                            end else begin
                                ev = EV_CHARGE;
                            end
                        end
                    end else begin
                        n_phase = 1'b0;
                        n_mux   = 1'b1;
                        load    = 1'b1;
                    end
                end
            end
            BK_DIV: begin
                // one restoring step per cycle
                if (trial >= {1'b0, i_charge_gain}) begin
                    n_rem = LEVEL_W'(trial - {1'b0, i_charge_gain});
                    n_quo = {r_quo[LEVEL_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[LEVEL_W-1:0];
                    n_quo = {r_quo[LEVEL_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'(LEVEL_W - 1)) begin
                    n_target = n_quo;
                    ev       = EV_HOST_OFF;
                    load     = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_host_on   <= 1'b1;
            r_phase     <= 1'b1;
            r_index     <= '0;
            r_target    <= '0;
            r_start     <= '0;
            r_mux       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_host_on <= n_host_on;
            r_phase   <= n_phase;
            r_index   <= n_index;
            r_target  <= n_target;
            r_start   <= n_start;
            r_mux     <= n_mux;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (load) begin
            r_out.mux_select     <= n_mux;
            r_out.host_on        <= n_host_on;
            r_out.charge_phase   <= n_phase;
            r_out.cycle_count    <= n_index;
            r_out.cycles_planned <= n_target;
            r_out.event_code     <= ev;
        end
    end

endmodule

[sv/duty_cycled_charge_sequencer.sv]
// top level of the duty-cycled charge sequencer: configuration registers,
// front end, pass queue and back end
// depends on dccs_pkg, dccs_front, dccs_queue, dccs_back
//
//  channel | direction | handshake               | word
//  in      | input     | i_in_valid / o_in_ready  | t_in_word (now, retries, level)
//  out     | output    | o_out_valid / i_out_ready| t_out_word (mux, host, phase, counts, event)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// a pass is classified on entry and queued (two entries); the back end takes one
// word per cycle while its output register is free, except a host-off pass with a
// non-zero plan, which holds it for the 7-step serial divider for the cycle plan
// reset: host on, charge phase, counts zero, registers at their defaults
// a waiting result holds the back end; the queue then fills and the input stalls
module duty_cycled_charge_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dccs_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dccs_pkg::t_out_word o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [dccs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dccs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dccs_pkg::*;

    t_cfg  r_cfg;
    t_pass front_pass;
    t_pass q_data;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  in_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign in_take     = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_retry_limit  <= RETRY_W'(3);
            r_cfg.max_charge_level <= LEVEL_W'(80);
            r_cfg.charge_gain      <= LEVEL_W'(5);
            r_cfg.charge_minutes   <= MINUTES_W'(10);
            r_cfg.cooldown_minutes <= MINUTES_W'(10);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFF_RETRY_LIMIT:  r_cfg.off_retry_limit  <= i_cfg_data;
                CFG_MAX_CHARGE_LEVEL: r_cfg.max_charge_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_CHARGE_GAIN:      r_cfg.charge_gain      <= i_cfg_data[LEVEL_W-1:0];
                CFG_CHARGE_MINUTES:   r_cfg.charge_minutes   <= i_cfg_data;
                CFG_COOLDOWN_MINUTES: r_cfg.cooldown_minutes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dccs_front u_front (
        .i_word (i_in_data),
        .i_cfg  (r_cfg),
        .o_pass (front_pass)
    );

    dccs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_take),
        .i_push_data (front_pass),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    dccs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_charge_gain (r_cfg.charge_gain),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
